// ----- rtl/bvff_pkg.sv -----
package bvff_pkg;

    // Storage word geometry.
    localparam int WORD_BITS = 64;
    localparam int OFS_W     = 6;

    // Field widths of the request, result and configuration transactions.
    localparam int INDEX_W = 10;
    localparam int SIZE_W  = 11;

    // Default store size and reset value of the active size register.
    localparam int DEFAULT_BITS = 1024;
    localparam logic [SIZE_W-1:0] ACTIVE_BITS_RESET = 11'd1024;

    // Request kinds.
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_FILL  = 2'd2,
        KIND_FIND  = 2'd3
    } kind_t;

endpackage

// ----- rtl/bit_vector_find_first_top.sv -----
// An index out of range is answered straight from the idle state; read and write pass
// through the read and modify states, fill writes every word, and find first searches
// one 64-bit word per cycle through the single memory read port, then locates the bit.
// One request is in flight at a time; the next is accepted in the cycle after the result
// transaction. Reset (synchronous, active low) starts a clearing pass, one word per
// cycle, during which no request is accepted.
module bit_vector_find_first_top
    import bvff_pkg::*;
#(
    parameter int BITS = DEFAULT_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [SIZE_W-1:0]  cfg_active_bits,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [INDEX_W-1:0] s_index,
    input  logic               s_value,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_status,
    output logic               m_bit_value,
    output logic [INDEX_W-1:0] m_found_index
);

    localparam int WORDS = (BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNTW  = $clog2(WORDS + 1);
    localparam int CW    = (CNTW + OFS_W > SIZE_W + 1) ? CNTW + OFS_W : SIZE_W + 1;
    localparam int BITS_CAP = (BITS > 2047) ? 2047 : BITS;
    localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(BITS_CAP);
    localparam logic [CNTW-1:0]   WORDS_C  = CNTW'(WORDS);
    localparam logic [CNTW-1:0]   LAST_C   = CNTW'(WORDS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_FILL,
        ST_FIND,
        ST_FFS,
        ST_RESP
    } state_t;

    state_t               state_reg, state_next;
    logic [SIZE_W-1:0]    active_bits_reg;
    kind_t                kind_reg, kind_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic                 val_reg, val_next;
    logic                 fill_val_reg, fill_val_next;
    logic [CNTW-1:0]      word_cnt_reg, word_cnt_next;
    logic [CNTW-1:0]      chk_cnt_reg, chk_cnt_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [63:0]          hit_word_reg, hit_word_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 status_reg, status_next;
    logic                 bit_value_reg, bit_value_next;
    logic [INDEX_W-1:0]   found_reg, found_next;

    logic [63:0]          store_mem [WORDS];
    logic [63:0]          rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [63:0]          mem_wdata;

    logic [SIZE_W-1:0]    size;
    logic [CW-1:0]        size_ext;
    logic [CW-1:0]        issue_base;
    logic [CW-1:0]        chk_base;
    logic [CW-1:0]        remain;
    logic [63:0]          tail_mask;
    logic [63:0]          search_word;
    logic                 issue_ok;
    logic                 in_range;
    logic [63:0]          bit_mask;
    logic [OFS_W-1:0]     ffs_pos;
    logic [CW-1:0]        found_full;

    // Lowest set bit of a nonzero word by a six-step halving search.
    function automatic logic [OFS_W-1:0] lowest_set(input logic [63:0] w);
        logic [OFS_W-1:0] pos;
        logic [63:0]      cur;
        pos = '0;
        cur = w;
        for (int s = OFS_W - 1; s >= 0; s--) begin
            if ((cur & ((64'd1 << (1 << s)) - 64'd1)) == 64'd0) begin
                pos[s] = 1'b1;
                cur    = cur >> (1 << s);
            end
        end
        return pos;
    endfunction

    assign cfg_ready     = 1'b1;
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_bit_value   = bit_value_reg;
    assign m_found_index = found_reg;

    // Active size clipped to the store.
    assign size     = (active_bits_reg > SIZE_CAP) ? SIZE_CAP : active_bits_reg;
    assign size_ext = CW'(size);

    // Request range check, done on the incoming index.
    assign in_range = (CW'(s_index) < size_ext) && (CW'(s_index[INDEX_W-1:OFS_W]) < CW'(WORDS));

    // Search window: the word being issued and the word being checked.
    assign issue_base  = CW'({word_cnt_reg, OFS_W'(0)});
    assign chk_base    = CW'({chk_cnt_reg, OFS_W'(0)});
    assign issue_ok    = (word_cnt_reg < WORDS_C) && (issue_base < size_ext);
    assign remain      = size_ext - chk_base;
    assign tail_mask   = (remain < CW'(WORD_BITS)) ?
                         ((64'd1 << remain[OFS_W-1:0]) - 64'd1) : {64{1'b1}};
    assign search_word = (val_reg ? rd_data_reg : ~rd_data_reg) & tail_mask;

    assign bit_mask   = 64'd1 << idx_reg[OFS_W-1:0];
    assign ffs_pos    = lowest_set(hit_word_reg);
    assign found_full = CW'({chk_cnt_reg, ffs_pos});

    assign rd_addr = (state_reg == ST_FIND) ? AW'(word_cnt_reg) : AW'(idx_reg[INDEX_W-1:OFS_W]);

    // Word store with one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_bits_reg <= ACTIVE_BITS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            active_bits_reg <= cfg_active_bits;
        end
    end

    // Sequencer next-state logic.
    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        fill_val_next  = fill_val_reg;
        word_cnt_next  = word_cnt_reg;
        chk_cnt_next   = chk_cnt_reg;
        chk_valid_next = chk_valid_reg;
        hit_word_next  = hit_word_reg;
        m_valid_next   = m_valid_reg;
        status_next    = status_reg;
        bit_value_next = bit_value_reg;
        found_next     = found_reg;
        mem_we         = 1'b0;
        mem_waddr      = AW'(word_cnt_reg);
        mem_wdata      = {64{fill_val_reg}};

        case (state_reg)
            ST_CLEAR, ST_FILL: begin
                mem_we = 1'b1;
                if (word_cnt_reg == LAST_C) begin
                    if (state_reg == ST_CLEAR) begin
                        state_next = ST_IDLE;
                    end else begin
                        m_valid_next   = 1'b1;
                        status_next    = 1'b0;
                        bit_value_next = 1'b0;
                        found_next     = '0;
                        state_next     = ST_RESP;
                    end
                end else begin
                    word_cnt_next = word_cnt_reg + 1'b1;
                end
            end

            ST_IDLE: begin
                if (s_valid) begin
                    kind_next      = kind_t'(s_kind);
                    idx_next       = s_index;
                    val_next       = s_value;
                    word_cnt_next  = '0;
                    chk_valid_next = 1'b0;
                    case (kind_t'(s_kind))
                        KIND_READ, KIND_WRITE: begin
                            if (in_range) begin
                                state_next = ST_READ;
                            end else begin
                                m_valid_next   = 1'b1;
                                status_next    = 1'b1;
                                bit_value_next = 1'b0;
                                found_next     = '0;
                                state_next     = ST_RESP;
                            end
                        end
                        KIND_FILL: begin
                            fill_val_next = s_value;
                            state_next    = ST_FILL;
                        end
                        KIND_FIND: begin
                            state_next = ST_FIND;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_READ: begin
                state_next = ST_MODIFY;
            end

            ST_MODIFY: begin
                // Read data is back; update the bit in place for a write.
                if (kind_reg == KIND_WRITE) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(idx_reg[INDEX_W-1:OFS_W]);
                    mem_wdata = val_reg ? (rd_data_reg | bit_mask) : (rd_data_reg & ~bit_mask);
                end
                m_valid_next   = 1'b1;
                status_next    = 1'b0;
                bit_value_next = rd_data_reg[idx_reg[OFS_W-1:0]];
                found_next     = '0;
                state_next     = ST_RESP;
            end

            ST_FIND: begin
                // One word issued and the previous one checked each cycle.
                if (chk_valid_reg && (search_word != 64'd0)) begin
                    hit_word_next = search_word;
                    state_next    = ST_FFS;
                end else if (!issue_ok) begin
                    m_valid_next   = 1'b1;
                    status_next    = 1'b1;
                    bit_value_next = 1'b0;
                    found_next     = '0;
                    state_next     = ST_RESP;
                end else begin
                    chk_cnt_next   = word_cnt_reg;
                    chk_valid_next = 1'b1;
                    word_cnt_next  = word_cnt_reg + 1'b1;
                end
            end

            ST_FFS: begin
                m_valid_next   = 1'b1;
                status_next    = 1'b0;
                bit_value_next = 1'b0;
                found_next     = found_full[INDEX_W-1:0];
                state_next     = ST_RESP;
            end

            ST_RESP: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            word_cnt_reg  <= '0;
            fill_val_reg  <= 1'b0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            word_cnt_reg  <= word_cnt_next;
            fill_val_reg  <= fill_val_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        kind_reg      <= kind_next;
        idx_reg       <= idx_next;
        val_reg       <= val_next;
        chk_cnt_reg   <= chk_cnt_next;
        hit_word_reg  <= hit_word_next;
        status_reg    <= status_next;
        bit_value_reg <= bit_value_next;
        found_reg     <= found_next;
    end

endmodule

// ----- rtl/bvff_checker.sv -----
module bvff_checker
    import bvff_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_status,
    input logic               m_bit_value,
    input logic [INDEX_W-1:0] m_found_index
);

    // The block never takes a request while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("request accepted while a result is pending");

    // Only one request is in flight at a time.
    assert property (@(posedge aclk) disable iff (!aresetn) (s_valid && s_ready) |=> !s_ready)
        else $error("second request accepted before the first finished");

    // A result is not repeated after its transaction.
    assert property (@(posedge aclk) disable iff (!aresetn) (m_valid && m_ready) |=> !m_valid)
        else $error("result repeated after its transaction");

    // A failed request never reports a bit value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_bit_value == 1'b0))
        else $error("failed request reports a bit value");

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_bit_value)
                                   && $stable(m_found_index)))
        else $error("stalled result changed");

endmodule

bind bit_vector_find_first_top bvff_checker u_bvff_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_bit_value   (m_bit_value),
    .m_found_index (m_found_index)
);

// ----- sim/tb_top.sv -----
module tb_top;
    import bvff_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BITS    = DEFAULT_BITS;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 92;
    localparam int LONG_HOLD     = 300;

    // One result transaction as the block reports it.
    typedef struct packed {
        logic               status;
        logic               bit_value;
        logic [INDEX_W-1:0] found_index;
    } answer_t;

    // A row of the directed table is either a request or a new active size.
    typedef enum logic {
        ROW_REQUEST,
        ROW_SIZE
    } row_op_t;

    typedef struct packed {
        row_op_t            op;
        kind_t              kind;
        logic [INDEX_W-1:0] index;
        logic               value;
        logic [SIZE_W-1:0]  size;
        logic               typed;
        answer_t            answer;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [SIZE_W-1:0]  cfg_active_bits;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_kind;
    logic [INDEX_W-1:0] s_index;
    logic               s_value;
    logic               m_valid;
    logic               m_ready;
    logic               m_status;
    logic               m_bit_value;
    logic [INDEX_W-1:0] m_found_index;

    // Shadow copy of the bitmap and of the active size register.
    logic [STORE_BITS-1:0] shadow_bits;
    logic [SIZE_W-1:0]     shadow_active;

    answer_t bitmap_answers[$];

    int  error_count;
    int  answers_checked;
    int  flagged_answers;
    int  kind_count[4];
    int  size_writes;
    bit  tx_no_gaps;
    bit  rx_no_stall;
    logic last_fill;

    stim_row_t directed_rows[27];

    bit_vector_find_first_top #(
        .BITS(STORE_BITS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_active_bits(cfg_active_bits),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_index        (s_index),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_bit_value    (m_bit_value),
        .m_found_index  (m_found_index)
    );

    // Clock.
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Hard limit on the run time.
    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Applies one request to the shadow bitmap and returns the answer it must produce.
    function automatic answer_t bitmap_request(input kind_t k, input logic [INDEX_W-1:0] idx,
                                               input logic v);
        answer_t r;
        int      in_use;
        int      p;
        r = '0;
        in_use = (int'(shadow_active) > STORE_BITS) ? STORE_BITS : int'(shadow_active);
        case (k)
            KIND_READ, KIND_WRITE: begin
                if (int'(idx) >= in_use) begin
                    r.status = 1'b1;
                end else begin
                    r.bit_value = shadow_bits[idx];
                    if (k == KIND_WRITE) begin
                        shadow_bits[idx] = v;
                    end
                end
            end
            KIND_FILL: begin
                shadow_bits = {STORE_BITS{v}};
            end
            default: begin
                // Lowest in-use position holding the searched value.
                r.status = 1'b1;
                for (p = 0; p < in_use && r.status; p++) begin
                    if (shadow_bits[p] == v) begin
                        r.status      = 1'b0;
                        r.found_index = p[INDEX_W-1:0];
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic stim_row_t row_req(input kind_t k, input int idx, input bit v);
        stim_row_t r;
        r       = '0;
        r.op    = ROW_REQUEST;
        r.kind  = k;
        r.index = idx[INDEX_W-1:0];
        r.value = v;
        return r;
    endfunction

    function automatic stim_row_t row_chk(input kind_t k, input int idx, input bit v,
                                          input bit st, input bit bv, input int fi);
        stim_row_t r;
        r                    = row_req(k, idx, v);
        r.typed              = 1'b1;
        r.answer.status      = st;
        r.answer.bit_value   = bv;
        r.answer.found_index = fi[INDEX_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t row_size(input int n);
        stim_row_t r;
        r      = '0;
        r.op   = ROW_SIZE;
        r.kind = KIND_READ;
        r.size = n[SIZE_W-1:0];
        return r;
    endfunction

    // Index mostly inside the active range, some around its edge, the rest anywhere.
    function automatic logic [INDEX_W-1:0] pick_index(input int size);
        int sel;
        int in_use;
        int pos;
        sel = $urandom_range(0, 99);
        in_use = (size > STORE_BITS) ? STORE_BITS : size;
        if (in_use > 0 && sel < 70) begin
            pos = $urandom_range(0, in_use - 1);
        end else if (sel < 85) begin
            pos = in_use + int'($urandom_range(0, 3)) - 2;
            if (pos < 0) begin
                pos = 0;
            end
            if (pos > STORE_BITS - 1) begin
                pos = STORE_BITS - 1;
            end
        end else begin
            pos = $urandom_range(0, STORE_BITS - 1);
        end
        return pos[INDEX_W-1:0];
    endfunction

    // Offers one request transaction and returns once it has been accepted.
    task automatic send_request(input kind_t k, input logic [INDEX_W-1:0] idx, input logic v,
                                input bit typed, input answer_t typed_answer);
        answer_t want;
        int      gap;
        want = bitmap_request(k, idx, v);
        if (typed) begin
            want = typed_answer;
        end
        kind_count[k]++;
        if (k == KIND_FILL) begin
            last_fill = v;
        end
        gap = tx_no_gaps ? 0 : $urandom_range(0, 14);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        bitmap_answers.push_back(want);
        s_valid <= 1'b1;
        s_kind  <= k;
        s_index <= idx;
        s_value <= v;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // Writes the active size once every outstanding answer has come back.
    task automatic set_active_bits(input logic [SIZE_W-1:0] n);
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (bitmap_answers.size() == 0);
        @(negedge aclk);
        cfg_valid       <= 1'b1;
        cfg_active_bits <= n;
        do @(posedge aclk); while (!cfg_ready);
        shadow_active = n;
        size_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls per transaction, plus long hold-offs that back up the block.
    initial begin : result_drain
        int stall;
        int taken;
        taken   = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (taken % 40 == 0) begin
                rx_no_stall = ($urandom_range(0, 2) == 0);
            end
            if (taken == 150 || taken == 650) begin
                stall = LONG_HOLD;
            end else begin
                stall = rx_no_stall ? 0 : $urandom_range(0, 14);
            end
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    // Compare every result transaction with the oldest outstanding answer.
    always @(posedge aclk) begin : result_check
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            answers_checked++;
            if (m_status) begin
                flagged_answers++;
            end
            if (bitmap_answers.size() == 0) begin
                $error("result transaction with no request outstanding");
                error_count++;
            end else begin
                want = bitmap_answers.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_status);
                    error_count++;
                end
                if (m_bit_value !== want.bit_value) begin
                    $error("bit_value: expected %0d, actual %0d", want.bit_value, m_bit_value);
                    error_count++;
                end
                if (m_found_index !== want.found_index) begin
                    $error("found_index: expected %0d, actual %0d",
                           want.found_index, m_found_index);
                    error_count++;
                end
            end
        end
    end

    // Reset, directed table, random phases, then drain and report.
    initial begin : stimulus
        int          phase;
        int          item;
        int          size;
        int          sel;
        int          drain;
        kind_t       k;
        logic        v;
        stim_row_t   row;
        int          phase_sizes[9];

        error_count     = 0;
        answers_checked = 0;
        flagged_answers = 0;
        size_writes     = 0;
        kind_count      = '{0, 0, 0, 0};
        tx_no_gaps      = 1'b0;
        rx_no_stall     = 1'b0;
        last_fill       = 1'b0;
        shadow_bits     = '0;
        shadow_active   = ACTIVE_BITS_RESET;

        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_active_bits = '0;
        s_valid         = 1'b0;
        s_kind          = KIND_READ;
        s_index         = '0;
        s_value         = 1'b0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset contents, both ends of the store, fills, searches, and size edge cases.
        directed_rows = '{
            row_chk(KIND_READ,    0, 0, 0, 0, 0),
            row_chk(KIND_FIND,    0, 1, 1, 0, 0),
            row_chk(KIND_FIND,    0, 0, 0, 0, 0),
            row_chk(KIND_WRITE, 1023, 1, 0, 0, 0),
            row_chk(KIND_READ, 1023, 0, 0, 1, 0),
            row_chk(KIND_FIND,    0, 1, 0, 0, 1023),
            row_chk(KIND_WRITE, 1023, 0, 0, 1, 0),
            row_chk(KIND_FILL,    0, 1, 0, 0, 0),
            row_chk(KIND_FIND,    0, 0, 1, 0, 0),
            row_chk(KIND_FIND,    0, 1, 0, 0, 0),
            row_chk(KIND_WRITE,   0, 0, 0, 1, 0),
            row_chk(KIND_FIND,    0, 0, 0, 0, 0),
            row_req(KIND_WRITE,   0, 1),
            row_req(KIND_WRITE, 640, 0),
            row_chk(KIND_FIND,    0, 0, 0, 0, 640),
            row_size(100),
            row_chk(KIND_READ,  100, 0, 1, 0, 0),
            row_chk(KIND_WRITE, 100, 0, 1, 0, 0),
            row_chk(KIND_READ,   99, 0, 0, 1, 0),
            row_chk(KIND_FIND,    0, 0, 1, 0, 0),
            row_size(0),
            row_chk(KIND_READ,    0, 0, 1, 0, 0),
            row_chk(KIND_FIND,    0, 1, 1, 0, 0),
            row_size(2047),
            row_chk(KIND_READ, 1023, 0, 0, 1, 0),
            row_chk(KIND_FIND,    0, 0, 0, 0, 640),
            row_chk(KIND_FILL,    0, 0, 0, 0, 0)
        };
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.op == ROW_SIZE) begin
                set_active_bits(row.size);
            end else begin
                send_request(row.kind, row.index, row.value, row.typed, row.answer);
            end
        end

        // Random phases, each under its own active size.
        phase_sizes = '{1024, 1, 64, 65, 63, 2047, 0, 513, 1000};
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase < 9) begin
                size = phase_sizes[phase];
            end else if (phase == RANDOM_PHASES - 1) begin
                size = $urandom_range(1025, 2047);
            end else begin
                size = $urandom_range(1, 1024);
            end
            set_active_bits(size[SIZE_W-1:0]);
            tx_no_gaps = ($urandom_range(0, 2) == 0);
            for (item = 0; item < PHASE_ITEMS; item++) begin
                sel = $urandom_range(0, 99);
                if (sel < 35) begin
                    k = KIND_READ;
                end else if (sel < 75) begin
                    k = KIND_WRITE;
                end else if (sel < 80) begin
                    k = KIND_FILL;
                end else begin
                    k = KIND_FIND;
                end
                // Writes mostly set the bit opposite to the last fill, so searches vary.
                if (k == KIND_WRITE) begin
                    v = ($urandom_range(0, 3) != 0) ? ~last_fill : last_fill;
                end else begin
                    v = 1'($urandom_range(0, 1));
                end
                send_request(k, pick_index(size), v, 1'b0, '0);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (bitmap_answers.size() == 0);
        for (drain = 0; drain < 40; drain++) begin
            @(posedge aclk);
        end

        $display("Covered %0d reads, %0d writes, %0d fills and %0d searches under %0d sizes.",
                 kind_count[KIND_READ], kind_count[KIND_WRITE], kind_count[KIND_FILL],
                 kind_count[KIND_FIND], size_writes);
        $display("Checked %0d results, %0d of them flagged as out of range or not found.",
                 answers_checked, flagged_answers);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
